// ----- hw/rtl/tbra_pkg.sv -----
// ----------------------------------------------------------------------------
// tbra_pkg: shared types and constants of the three-band RMS analyzer
// Field widths, register indexes, fixed-point scaling and the handshake
// status that the serial arithmetic units report to the sequencer.
// ----------------------------------------------------------------------------
package tbra_pkg;

    localparam int SAMPLE_W    = 16;   // Q1.15 channel sample
    localparam int NUM_SAMPLES = 8;    // sample slots in one frame
    localparam int CNT_W       = 4;    // channel_count register
    localparam int ALPHA_W     = 17;   // Q1.16 gain, 65536 = 1.0
    localparam int FILT_W      = 24;   // Q2.22 filter state
    localparam int ENERGY_W    = 64;   // sum of squares, units of 2^-30
    localparam int LEVEL_W     = 18;   // Q3.15 RMS level
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = ALPHA_W;

    localparam int MONO_SHIFT  = 7;    // Q1.15 -> Q2.22
    localparam int ALPHA_FRAC  = 16;
    localparam int SQ_SHIFT    = 14;   // Q4.44 square -> units of 2^-30

    localparam int MAX_CHANNELS_DEF = 8;
    localparam int MAX_WINDOW_DEF   = 2048;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;
    localparam logic [ALPHA_W-1:0] ROUND_HALF = 17'd32768;

    localparam logic [CNT_W-1:0]   CHANNEL_COUNT_RST = 4'd2;
    localparam logic [ALPHA_W-1:0] ALPHA_LOW_RST     = 17'd2077;
    localparam logic [ALPHA_W-1:0] ALPHA_MID_RST     = 17'd22522;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LOW     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_MID     = 2'd2;

    // status of a serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;    // one-cycle pulse, result valid from here until next start
    } unit_stat_t;

endpackage

// ----- hw/rtl/tbra_mul.sv -----
// ----------------------------------------------------------------------------
// tbra_mul: bit-serial unsigned multiplier
// Shift-add over one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module tbra_mul
    import tbra_pkg::*;
#(
    parameter int W = 25
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [W-1:0]     op_a,
    input  logic [W-1:0]     op_b,
    output logic [2*W-1:0]   product,
    output unit_stat_t       stat
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  a_reg;
    logic [W-1:0]  hi_reg, hi_next;
    logic [W-1:0]  lo_reg, lo_next;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg;
    logic [W:0]    sum;

    always_comb begin
        sum     = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);
        hi_next = sum[W:1];
        lo_next = {sum[0], lo_reg[W-1:1]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg  <= op_a;
            hi_reg <= '0;
            lo_reg <= op_b;
        end else if (busy_reg) begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    assign product   = {hi_reg, lo_reg};
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ----- hw/rtl/tbra_div.sv -----
// ----------------------------------------------------------------------------
// tbra_div: bit-serial unsigned restoring divider
// One quotient bit per cycle, most significant first.
// ----------------------------------------------------------------------------
module tbra_div
    import tbra_pkg::*;
#(
    parameter int NW = 64,
    parameter int DW = 12
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic [NW-1:0] quotient,
    output unit_stat_t    stat
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] quo_reg;
    logic [DW-1:0] rem_reg, d_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg;
    logic [DW:0]   r2, diff;
    logic          ge;

    always_comb begin
        r2   = {rem_reg, quo_reg[NW-1]};
        ge   = (r2 >= {1'b0, d_reg});
        diff = r2 - {1'b0, d_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            d_reg   <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[NW-2:0], ge};
            rem_reg <= ge ? diff[DW-1:0] : r2[DW-1:0];
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ----- hw/rtl/tbra_sqrt.sv -----
// ----------------------------------------------------------------------------
// tbra_sqrt: digit-serial integer square root
// Two radicand bits per cycle, one root bit out; floor result.
// ----------------------------------------------------------------------------
module tbra_sqrt
    import tbra_pkg::*;
#(
    parameter int NW = 64
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [NW-1:0]   radicand,
    output logic [NW/2-1:0] root,
    output unit_stat_t      stat
);

    localparam int RW = NW / 2;
    localparam int CW = $clog2(RW + 1);

    logic [NW-1:0] rad_reg;
    logic [RW:0]   rem_reg;
    logic [RW-1:0] root_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg;
    logic [RW+2:0] r4, trial, diff;
    logic          ge;

    always_comb begin
        r4    = {rem_reg, rad_reg[NW-1:NW-2]};
        trial = {1'b0, root_reg, 2'b01};
        ge    = (r4 >= trial);
        diff  = r4 - trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(RW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[NW-3:0], 2'b00};
            rem_reg  <= ge ? diff[RW:0] : r4[RW:0];
            root_reg <= {root_reg[RW-2:0], ge};
        end
    end

    assign root      = root_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ----- hw/rtl/three_band_rms_analyzer.sv -----
// ----------------------------------------------------------------------------
// three_band_rms_analyzer: three-band RMS level meter
// Averages up to eight channels to mono, splits it with two cascaded one-pole
// low-pass filters into low, mid and high bands, and reports the RMS level of
// each band at the end of every analysis window.
// ----------------------------------------------------------------------------
// Usage: each input transfer carries one frame (eight Q1.15 samples in s_tdata,
// end of window on s_tlast). Frames are handled one at a time: s_tready is
// high only while the sequencer is idle. Most of a frame's time goes to the
// bit-serial 25-bit multiplier, which runs five products per frame (two filter
// gains, three squares), and to the bit-serial divider that forms the channel
// average. A frame with tlast adds three level computations (a 64-bit
// bit-serial divide by the frame count, then a two-bit-per-cycle square
// root). A result sits in the output register until taken; the next frame is
// accepted meanwhile, and only the next window end waits for the output
// register to drain. Results go out as one transfer with three Q3.15 levels
// in m_tdata and the window overflow flag in m_tuser. Once a window holds
// MAX_WINDOW frames, further frames are dropped and set the flag; a tlast on
// a dropped frame still closes the window. Write the configuration registers
// only while the block is idle.
// ----------------------------------------------------------------------------
module three_band_rms_analyzer
    import tbra_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    parameter int MAX_WINDOW   = MAX_WINDOW_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write port
    input  logic                             cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]             cfg_index,
    input  logic [CFG_DATA_W-1:0]            cfg_wdata,
    // frame input
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [NUM_SAMPLES*SAMPLE_W-1:0]  s_tdata,   // sample_0 .. sample_7
    input  logic                             s_tlast,   // last_frame
    // level output
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [55:0]                      m_tdata,   // low_level, mid_level,
                                                        // high_level, 2 pad bits
    output logic                             m_tuser    // window_overflow
);

    // widths that follow from the parameters
    localparam int SUM_W   = SAMPLE_W + $clog2(MAX_CHANNELS);
    localparam int MONO_NW = SUM_W + MONO_SHIFT;
    localparam int FW      = $clog2(MAX_WINDOW + 1);
    localparam int MW      = FILT_W + 1;          // magnitude operand width
    localparam int PW      = 2 * MW + 1;          // signed product width
    localparam int RW      = ENERGY_W / 2;

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SUM   = 4'd1;
    localparam logic [3:0] S_MONO  = 4'd2;
    localparam logic [3:0] S_LOW   = 4'd3;
    localparam logic [3:0] S_MID   = 4'd4;
    localparam logic [3:0] S_SQL   = 4'd5;
    localparam logic [3:0] S_SQM   = 4'd6;
    localparam logic [3:0] S_SQH   = 4'd7;
    localparam logic [3:0] S_END   = 4'd8;
    localparam logic [3:0] S_LDIV  = 4'd9;
    localparam logic [3:0] S_LSQRT = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    // configuration
    logic [CNT_W-1:0]   channel_count_reg;
    logic [ALPHA_W-1:0] alpha_low_reg, alpha_mid_reg;

    // control
    logic [3:0] state_reg, state_next;
    logic       kick_reg;                     // first cycle in a state
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0] band_reg, band_next;

    // frame payload and window state
    logic [NUM_SAMPLES*SAMPLE_W-1:0] samples_reg, samples_next;
    logic                            last_reg, last_next;
    logic signed [SUM_W-1:0]         sum_reg, sum_next;
    logic signed [FILT_W-1:0]        mono_reg, mono_next;
    logic signed [FILT_W:0]          hp_reg, hp_next;
    logic signed [FILT_W-1:0]        low_reg, low_next;
    logic signed [FILT_W-1:0]        mid_reg, mid_next;
    logic [ENERGY_W-1:0]             e_low_reg, e_low_next;
    logic [ENERGY_W-1:0]             e_mid_reg, e_mid_next;
    logic [ENERGY_W-1:0]             e_high_reg, e_high_next;
    logic [FW-1:0]                   frames_reg, frames_next;
    logic                            ovf_reg, ovf_next;
    logic [3*LEVEL_W-1:0]            lvl_reg, lvl_next;

    // output register
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [3*LEVEL_W-1:0] m_data_reg, m_data_next;
    logic                 m_user_reg, m_user_next;
    logic                 out_load;

    // arithmetic units
    logic                  mul_start, mdiv_start, ldiv_start, sqrt_start;
    logic [MW-1:0]         mul_a, mul_b;
    logic [2*MW-1:0]       mul_p;
    logic [MONO_NW-1:0]    mdiv_q;
    logic [ENERGY_W-1:0]   ldiv_q, e_sel;
    logic [RW-1:0]         sqrt_root;
    unit_stat_t            mul_stat, mdiv_stat, ldiv_stat, sqrt_stat;

    // derived values
    logic [CNT_W-1:0]         n_eff;
    logic [ALPHA_W-1:0]       alpha_low_sat, alpha_mid_sat;
    logic [SUM_W-1:0]         sum_mag;
    logic [FILT_W-1:0]        mono_abs;
    logic signed [FILT_W:0]   d_low;
    logic signed [FILT_W+1:0] d_mid;          // also the high band in S_SQH
    logic [FILT_W:0]          mag_dlow;
    logic [FILT_W+1:0]        mag_dmid_w;
    logic [FILT_W-1:0]        mag_low, mag_mid;
    logic signed [FILT_W-1:0] low_upd, mid_upd;
    logic [LEVEL_W-1:0]       lvl_new;
    logic [ENERGY_W-1:0]      sq_add;

    // y + floor((alpha * (x - y) + 1/2 lsb) / 2^16) from the unsigned product
    function automatic logic signed [FILT_W-1:0] filt_step(
        input logic signed [FILT_W-1:0] y,
        input logic [2*MW-1:0]          p,
        input logic                     neg
    );
        logic signed [PW-1:0] sp;
        logic signed [PW-1:0] rnd;
        sp  = neg ? -$signed({1'b0, p}) : $signed({1'b0, p});
        rnd = sp + $signed(PW'(ROUND_HALF));
        return y + FILT_W'(rnd >>> ALPHA_FRAC);
    endfunction

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channel_count_reg <= CHANNEL_COUNT_RST;
            alpha_low_reg     <= ALPHA_LOW_RST;
            alpha_mid_reg     <= ALPHA_MID_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_CHANNEL_COUNT: channel_count_reg <= cfg_wdata[CNT_W-1:0];
                CFG_ALPHA_LOW:     alpha_low_reg     <= cfg_wdata;
                CFG_ALPHA_MID:     alpha_mid_reg     <= cfg_wdata;
                default: ;   // unused index: drop the write
            endcase
        end
    end

    // clamp channel count to 1..MAX_CHANNELS and gains to 1.0
    always_comb begin
        if (channel_count_reg == '0) begin
            n_eff = CNT_W'(1);
        end else if (channel_count_reg > CNT_W'(MAX_CHANNELS)) begin
            n_eff = CNT_W'(MAX_CHANNELS);
        end else begin
            n_eff = channel_count_reg;
        end
        alpha_low_sat = (alpha_low_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_low_reg;
        alpha_mid_sat = (alpha_mid_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_mid_reg;
    end

    // band differences and magnitudes fed to the serial multiplier
    always_comb begin
        sum_mag    = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        mono_abs   = FILT_W'(mdiv_q);
        d_low      = {mono_reg[FILT_W-1], mono_reg} - {low_reg[FILT_W-1], low_reg};
        d_mid      = {hp_reg[FILT_W], hp_reg} - {{2{mid_reg[FILT_W-1]}}, mid_reg};
        mag_dlow   = d_low[FILT_W] ? (FILT_W+1)'(-d_low) : (FILT_W+1)'(d_low);
        mag_dmid_w = d_mid[FILT_W+1] ? (FILT_W+2)'(-d_mid) : (FILT_W+2)'(d_mid);
        mag_low    = low_reg[FILT_W-1] ? FILT_W'(-low_reg) : FILT_W'(low_reg);
        mag_mid    = mid_reg[FILT_W-1] ? FILT_W'(-mid_reg) : FILT_W'(mid_reg);
        low_upd    = filt_step(low_reg, mul_p, d_low[FILT_W]);
        mid_upd    = filt_step(mid_reg, mul_p, d_mid[FILT_W+1]);
        sq_add     = ENERGY_W'(mul_p[2*MW-1:SQ_SHIFT]);
    end

    always_comb begin
        case (state_reg)
            S_LOW: begin
                mul_a = MW'(alpha_low_sat);
                mul_b = mag_dlow;
            end
            S_MID: begin
                mul_a = MW'(alpha_mid_sat);
                mul_b = mag_dmid_w[MW-1:0];
            end
            S_SQL: begin
                mul_a = MW'(mag_low);
                mul_b = MW'(mag_low);
            end
            S_SQM: begin
                mul_a = MW'(mag_mid);
                mul_b = MW'(mag_mid);
            end
            default: begin
                mul_a = mag_dmid_w[MW-1:0];
                mul_b = mag_dmid_w[MW-1:0];
            end
        endcase
        case (band_reg)
            2'd0:    e_sel = e_low_reg;
            2'd1:    e_sel = e_mid_reg;
            default: e_sel = e_high_reg;
        endcase
    end

    assign mul_start  = kick_reg && ((state_reg == S_LOW) || (state_reg == S_MID) ||
                        (state_reg == S_SQL) || (state_reg == S_SQM) ||
                        (state_reg == S_SQH));
    assign mdiv_start = kick_reg && (state_reg == S_MONO);
    assign ldiv_start = kick_reg && (state_reg == S_LDIV);
    assign sqrt_start = kick_reg && (state_reg == S_LSQRT);

    // saturate the root to Q3.15; an empty window reads as zero
    always_comb begin
        if (frames_reg == '0) begin
            lvl_new = '0;
        end else if (|sqrt_root[RW-1:LEVEL_W]) begin
            lvl_new = '1;
        end else begin
            lvl_new = sqrt_root[LEVEL_W-1:0];
        end
    end

    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    // sequencer
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        band_next    = band_reg;
        samples_next = samples_reg;
        last_next    = last_reg;
        sum_next     = sum_reg;
        mono_next    = mono_reg;
        hp_next      = hp_reg;
        low_next     = low_reg;
        mid_next     = mid_reg;
        e_low_next   = e_low_reg;
        e_mid_next   = e_mid_reg;
        e_high_next  = e_high_reg;
        frames_next  = frames_reg;
        ovf_next     = ovf_reg;
        lvl_next     = lvl_reg;

        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    samples_next = s_tdata;
                    last_next    = s_tlast;
                    if (frames_reg >= FW'(MAX_WINDOW)) begin
                        // window full: drop the frame, keep the end mark
                        ovf_next   = 1'b1;
                        state_next = S_END;
                    end else begin
                        cnt_next   = '0;
                        sum_next   = '0;
                        state_next = S_SUM;
                    end
                end
            end
            S_SUM: begin
                // one channel per cycle off the bottom of the sample shifter
                if (cnt_reg == n_eff) begin
                    state_next = S_MONO;
                end else begin
                    sum_next     = sum_reg + SUM_W'($signed(samples_reg[SAMPLE_W-1:0]));
                    samples_next = samples_reg >> SAMPLE_W;
                    cnt_next     = cnt_reg + 1'b1;
                end
            end
            S_MONO: begin
                if (mdiv_stat.done) begin
                    mono_next  = sum_reg[SUM_W-1] ? -mono_abs : mono_abs;
                    state_next = S_LOW;
                end
            end
            S_LOW: begin
                if (mul_stat.done) begin
                    low_next   = low_upd;
                    hp_next    = {mono_reg[FILT_W-1], mono_reg} -
                                 {low_upd[FILT_W-1], low_upd};
                    state_next = S_MID;
                end
            end
            S_MID: begin
                if (mul_stat.done) begin
                    mid_next   = mid_upd;
                    state_next = S_SQL;
                end
            end
            S_SQL: begin
                if (mul_stat.done) begin
                    e_low_next = e_low_reg + sq_add;
                    state_next = S_SQM;
                end
            end
            S_SQM: begin
                if (mul_stat.done) begin
                    e_mid_next = e_mid_reg + sq_add;
                    state_next = S_SQH;
                end
            end
            S_SQH: begin
                if (mul_stat.done) begin
                    e_high_next = e_high_reg + sq_add;
                    frames_next = frames_reg + 1'b1;
                    state_next  = S_END;
                end
            end
            S_END: begin
                band_next  = '0;
                state_next = last_reg ? S_LDIV : S_IDLE;
            end
            S_LDIV: begin
                if (ldiv_stat.done) begin
                    state_next = S_LSQRT;
                end
            end
            S_LSQRT: begin
                if (sqrt_stat.done) begin
                    // shift each level in at the top so low lands at the bottom
                    lvl_next = {lvl_new, lvl_reg[3*LEVEL_W-1:LEVEL_W]};
                    if (band_reg == 2'd2) begin
                        state_next = S_OUT;
                    end else begin
                        band_next  = band_reg + 1'b1;
                        state_next = S_LDIV;
                    end
                end
            end
            S_OUT: begin
                if (out_load) begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = lvl_reg;
                    m_user_next   = ovf_reg;
                    low_next      = '0;
                    mid_next      = '0;
                    e_low_next    = '0;
                    e_mid_next    = '0;
                    e_high_next   = '0;
                    frames_next   = '0;
                    ovf_next      = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            kick_reg     <= 1'b0;
            cnt_reg      <= '0;
            band_reg     <= '0;
            low_reg      <= '0;
            mid_reg      <= '0;
            e_low_reg    <= '0;
            e_mid_reg    <= '0;
            e_high_reg   <= '0;
            frames_reg   <= '0;
            ovf_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            kick_reg     <= (state_next != state_reg);
            cnt_reg      <= cnt_next;
            band_reg     <= band_next;
            low_reg      <= low_next;
            mid_reg      <= mid_next;
            e_low_reg    <= e_low_next;
            e_mid_reg    <= e_mid_next;
            e_high_reg   <= e_high_next;
            frames_reg   <= frames_next;
            ovf_reg      <= ovf_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        samples_reg <= samples_next;
        last_reg    <= last_next;
        sum_reg     <= sum_next;
        mono_reg    <= mono_next;
        hp_reg      <= hp_next;
        lvl_reg     <= lvl_next;
        m_data_reg  <= m_data_next;
        m_user_reg  <= m_user_next;
    end

    tbra_mul #(
        .W (MW)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (mul_p),
        .stat    (mul_stat)
    );

    tbra_div #(
        .NW (MONO_NW),
        .DW (CNT_W)
    ) u_mono_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mdiv_start),
        .dividend ({sum_mag, MONO_SHIFT'(0)}),
        .divisor  (n_eff),
        .quotient (mdiv_q),
        .stat     (mdiv_stat)
    );

    tbra_div #(
        .NW (ENERGY_W),
        .DW (FW)
    ) u_level_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (ldiv_start),
        .dividend (e_sel),
        .divisor  (frames_reg),
        .quotient (ldiv_q),
        .stat     (ldiv_stat)
    );

    tbra_sqrt #(
        .NW (ENERGY_W)
    ) u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (ldiv_q),
        .root     (sqrt_root),
        .stat     (sqrt_stat)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, m_data_reg};
    assign m_tuser  = m_user_reg;

    // frame count never passes the window limit
    a_frames_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        frames_reg <= FW'(MAX_WINDOW))
        else $error("frame count beyond window limit");

    // a frame arriving on a full window marks overflow
    a_drop_sets_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (frames_reg == FW'(MAX_WINDOW))) |=> ovf_reg)
        else $error("dropped frame did not set overflow");

    // emitting a result clears the window
    a_window_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> ((frames_reg == '0) && !ovf_reg && (low_reg == '0) &&
                      (e_high_reg == '0)))
        else $error("window not cleared after result");

    // the shared multiplier is never restarted mid-product
    a_mul_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_start |-> !mul_stat.busy)
        else $error("multiplier started while busy");

endmodule

// ----- test/tb_three_band_rms_analyzer.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_three_band_rms_analyzer: self-checking bench for the three-band RMS meter
// Feeds audio frames through the input stream and predicts the window levels
// with a local fixed-point band splitter. Checks every level transfer field by
// field, under random idling on both sides, several register settings, a long
// output hold-off and one window long enough to overflow.
// ----------------------------------------------------------------------------
module tb_three_band_rms_analyzer;
    import tbra_pkg::*;

    localparam int WINDOW_LIMIT = MAX_WINDOW_DEF;
    localparam int DRAIN_CYCLES = 800;

    typedef struct {
        logic signed [SAMPLE_W-1:0] smp [NUM_SAMPLES];
        logic                       last;
    } frame_t;

    typedef struct {
        logic [LEVEL_W-1:0] low_lvl;
        logic [LEVEL_W-1:0] mid_lvl;
        logic [LEVEL_W-1:0] high_lvl;
        logic               ovf;
    } levels_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [NUM_SAMPLES*SAMPLE_W-1:0] s_tdata = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic m_tuser;

    three_band_rms_analyzer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Frames waiting to go out, and levels waiting to come back
    frame_t  frame_q [$];
    levels_t level_q [$];
    frame_t  cur_frame;
    int      mismatches = 0;
    bit      quiet = 1'b0;        // no idling on either side
    bit      hold_req = 1'b0;     // ask the receiver for one long hold-off

    // Mirror of the configuration registers
    logic [CNT_W-1:0]   chan_cnt = CHANNEL_COUNT_RST;
    logic [ALPHA_W-1:0] gain_low = ALPHA_LOW_RST;
    logic [ALPHA_W-1:0] gain_mid = ALPHA_MID_RST;

    // Mirror of the window state
    longint             lp_low = 0;
    longint             lp_mid = 0;
    longint unsigned    e_low = 0, e_mid = 0, e_high = 0;
    int                 n_frames = 0;
    bit                 win_ovf = 1'b0;

    function automatic longint filter_step(longint y, longint x, logic [ALPHA_W-1:0] g);
        longint a;
        a = (g > ALPHA_ONE) ? 65536 : longint'(g);
        // arithmetic shift floors, which gives round half up
        return y + ((a * (x - y) + 32768) >>> 16);
    endfunction

    function automatic longint unsigned band_energy(longint v);
        longint unsigned m;
        m = (v < 0) ? -v : v;
        return (m * m) >> SQ_SHIFT;
    endfunction

    function automatic logic [LEVEL_W-1:0] rms_level(longint unsigned e, int n);
        longint unsigned x, res, b;
        if (n == 0) return '0;
        x = e / longint'(n);
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return (res > 262143) ? 18'h3FFFF : res[LEVEL_W-1:0];
    endfunction

    // Advance the window state by one accepted frame; queue levels on a last frame
    task automatic band_split(frame_t f);
        int      n;
        longint  sum, mono, hp;
        levels_t lv;
        n = (chan_cnt == 0) ? 1 : (chan_cnt > 8 ? 8 : int'(chan_cnt));
        if (n_frames >= WINDOW_LIMIT) begin
            win_ovf = 1'b1;
        end else begin
            sum = 0;
            for (int i = 0; i < n; i++) sum += longint'(f.smp[i]);
            mono = (sum * 128) / n;
            lp_low = filter_step(lp_low, mono, gain_low);
            hp = mono - lp_low;
            lp_mid = filter_step(lp_mid, hp, gain_mid);
            e_low += band_energy(lp_low);
            e_mid += band_energy(lp_mid);
            e_high += band_energy(hp - lp_mid);
            n_frames++;
        end
        if (f.last) begin
            lv.low_lvl = rms_level(e_low, n_frames);
            lv.mid_lvl = rms_level(e_mid, n_frames);
            lv.high_lvl = rms_level(e_high, n_frames);
            lv.ovf = win_ovf;
            level_q.push_back(lv);
            lp_low = 0; lp_mid = 0;
            e_low = 0; e_mid = 0; e_high = 0;
            n_frames = 0; win_ovf = 1'b0;
        end
    endtask

    task automatic report(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d, want %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Frame driver: hold the frame until the transfer, then advance
    int tx_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) band_split(cur_frame);
            if (tx_gap > 0 && !quiet) begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end else if (frame_q.size() > 0) begin
                cur_frame = frame_q.pop_front();
                for (int i = 0; i < NUM_SAMPLES; i++)
                    s_tdata[i*SAMPLE_W +: SAMPLE_W] <= cur_frame.smp[i];
                s_tlast <= cur_frame.last;
                s_tvalid <= 1'b1;
                tx_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 18) : 0;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Level receiver: random stalls, plus one long hold-off on request
    int rx_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (hold_req) begin
                hold_req = 1'b0;
                rx_gap = 3000;
            end
            if (rx_gap > 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                rx_gap = $urandom_range(1, 18) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Level monitor: compare each transfer with the oldest prediction
    always @(posedge aclk) begin
        levels_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (level_q.size() == 0) begin
                report("unexpected level transfer", m_tdata[17:0], -1);
            end else begin
                w = level_q.pop_front();
                if (m_tdata[17:0] !== w.low_lvl) report("low_level", m_tdata[17:0], w.low_lvl);
                if (m_tdata[35:18] !== w.mid_lvl)
                    report("mid_level", m_tdata[35:18], w.mid_lvl);
                if (m_tdata[53:36] !== w.high_lvl)
                    report("high_level", m_tdata[53:36], w.high_lvl);
                if (m_tuser !== w.ovf) report("window_overflow", m_tuser, w.ovf);
            end
        end
    end

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return SAMPLE_W'($urandom_range(0, 255) - 128);
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    task automatic add_frame(logic last, int kind);
        frame_t f;
        for (int i = 0; i < NUM_SAMPLES; i++) begin
            case (kind)
                1:       f.smp[i] = 16'sh7FFF;
                2:       f.smp[i] = 16'sh8000;
                3:       f.smp[i] = '0;
                4:       f.smp[i] = (i % 2) ? 16'sh8000 : 16'sh7FFF;
                default: f.smp[i] = pick_sample();
            endcase
        end
        f.last = last;
        frame_q.push_back(f);
    endtask

    // Mostly whole windows of random length, with some loose frames
    task automatic add_windows(int count);
        int len;
        for (int k = 0; k < count; k++) begin
            len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 14);
            for (int j = 0; j < len; j++) add_frame(j == len - 1, 0);
            if ($urandom_range(0, 5) == 0) add_frame(1'b0, 0);
        end
    endtask

    // Wait for every frame to go and every level to return, then let work drain
    task automatic drain();
        while (frame_q.size() > 0 || s_tvalid || level_q.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_CHANNEL_COUNT: chan_cnt = val[CNT_W-1:0];
            CFG_ALPHA_LOW:     gain_low = val;
            CFG_ALPHA_MID:     gain_mid = val;
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic setup(int cc, int al, int am);
        drain();
        write_reg(CFG_CHANNEL_COUNT, CFG_DATA_W'(cc));
        write_reg(CFG_ALPHA_LOW, CFG_DATA_W'(al));
        write_reg(CFG_ALPHA_MID, CFG_DATA_W'(am));
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes under reset settings, then odd register values
        add_frame(1'b1, 1);
        add_frame(1'b1, 2);
        add_frame(1'b1, 3);
        add_frame(1'b0, 4);
        add_frame(1'b0, 1);
        add_frame(1'b1, 2);
        add_frame(1'b0, 0);
        add_frame(1'b1, 0);
        setup(8, 65536, 65536);
        add_frame(1'b0, 1);
        add_frame(1'b0, 2);
        add_frame(1'b1, 4);
        setup(0, 131071, 0);             // zero channels act as one, gain above 1.0
        add_frame(1'b0, 2);
        add_frame(1'b1, 1);
        setup(15, 0, 131071);            // channel count saturates at eight
        add_frame(1'b0, 1);
        add_frame(1'b1, 2);
        add_frame(1'b0, 4);
        add_frame(1'b1, 0);

        // Random windows across settings
        setup(int'(CHANNEL_COUNT_RST), int'(ALPHA_LOW_RST), int'(ALPHA_MID_RST));
        add_windows(12);
        setup(1, 65536, 32768);
        add_windows(10);
        setup(8, 1, 1);
        add_windows(10);
        hold_req = 1'b1;                 // stall the output while frames keep coming
        setup(3, 40000, 5000);
        add_windows(10);
        setup($urandom_range(0, 15), $urandom_range(0, 131071), $urandom_range(0, 131071));
        add_windows(10);

        // One window past the frame limit, closed by a dropped frame
        setup(1, 30000, 20000);
        for (int j = 0; j <= WINDOW_LIMIT; j++) add_frame(j == WINDOW_LIMIT, 0);
        add_windows(2);

        // Final stretch with both sides always ready
        setup(5, 12345, 54321);
        quiet = 1'b1;
        add_windows(6);
        drain();

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #100ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
